FILE: hdl/hkts_pkg.sv
// ----------------------------------------------------------------------------
// hkts_pkg
// Shared types and constants for the top-k frequency sketch unit.
// ----------------------------------------------------------------------------
package hkts_pkg;

    // parameter defaults
    localparam int ROWS_DEF        = 4;
    localparam int COLS_DEF        = 1024;
    localparam int TOPK_DEF        = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int FP_W     = 64;
    localparam int RND_W    = 31;
    localparam int RND_ROWS = 4;
    localparam int EST_W    = 16;
    localparam int THR_W    = 16;
    localparam int BASE_W   = 20;
    localparam int RANK_W   = 4;
    localparam int OP_W     = 2;
    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 168;

    // decay power: Q16 accumulator, divisor limit 2^31-1 => 47 bits
    localparam int P_W             = 47;
    localparam logic [P_W-1:0] Q16_ONE = P_W'(65536);

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_THR  = 1'b0;
    localparam logic REG_BASE = 1'b1;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd10;
    localparam logic [BASE_W-1:0] BASE_RESET = 20'd70779;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // rank cursor updates
    typedef enum logic [2:0] {
        RK_HOLD,
        RK_ZERO,
        RK_INC,
        RK_INPUT,
        RK_LAST,
        RK_OCC,
        RK_PRANK
    } rank_op_t;

    // controller states
    typedef enum logic [4:0] {
        ST_BOOT_CLR,
        ST_IDLE,
        ST_CLEAR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_HASH,
        ST_SRCH_ADDR,
        ST_SRCH_DATA,
        ST_ROW_RD,
        ST_ROW_CHK,
        ST_POW,
        ST_DIV,
        ST_DECAY,
        ST_STORE,
        ST_EV_RD,
        ST_EV_DATA,
        ST_UPD,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        rank_op_t rank_op;
        logic     hash_step;
        logic     top_rd;
        logic     srch_cmp;
        logic     rd_cap;
        logic     bkt_rd;
        logic     row_hit;
        logic     row_inc;
        logic     pow_start;
        logic     pow_step;
        logic     div_start;
        logic     div_step;
        logic     row_decay;
        logic     ev_cap;
        logic     upd;
        logic     clr_step;
        logic     res_load;
    } hkts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_last;
        logic srch_more;
        logic top_match;
        logic bkt_match;
        logic row_last;
        logic pow_done;
        logic pow_nodecay;
        logic div_done;
        logic rem_zero;
        logic admit;
        logic refresh;
        logic full;
        logic rd_ok;
        logic clr_last;
        logic out_free;
    } hkts_stat_t;

endpackage

FILE: hdl/hkts_ctrl.sv
// ----------------------------------------------------------------------------
// hkts_ctrl
// Sequencer for the sketch unit: walks each operation through its steps.
// ----------------------------------------------------------------------------
module hkts_ctrl
    import hkts_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] s_op,
    output logic            s_tready,
    input  hkts_stat_t      stat,
    output hkts_cmd_t       cmd
);

    state_t state_reg, state_next;

    // state register; reset starts with a clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BOOT_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        logic row_done;
        row_done   = 1'b0;
        cmd        = '0;
        cmd.rank_op = RK_HOLD;
        state_next = state_reg;
        s_tready   = 1'b0;

        unique case (state_reg)
            ST_BOOT_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    unique case (op_t'(s_op))
                        OP_INSERT: begin
                            cmd.rank_op = RK_ZERO;
                            state_next  = ST_HASH;
                        end
                        OP_READ: begin
                            cmd.rank_op = RK_INPUT;
                            state_next  = ST_RD_ADDR;
                        end
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_FINISH;
            end
            ST_RD_ADDR: begin
                if (stat.rd_ok) begin
                    cmd.top_rd = 1'b1;
                    state_next = ST_RD_DATA;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_RD_DATA: begin
                cmd.rd_cap = 1'b1;
                state_next = ST_FINISH;
            end
            ST_HASH: begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last) state_next = ST_SRCH_ADDR;
            end
            ST_SRCH_ADDR: begin
                if (stat.srch_more) begin
                    cmd.top_rd = 1'b1;
                    state_next = ST_SRCH_DATA;
                end else begin
                    state_next = ST_ROW_RD;
                end
            end
            ST_SRCH_DATA: begin
                cmd.srch_cmp = 1'b1;
                if (stat.top_match) begin
                    state_next = ST_ROW_RD;
                end else begin
                    cmd.rank_op = RK_INC;
                    state_next  = ST_SRCH_ADDR;
                end
            end
            ST_ROW_RD: begin
                cmd.bkt_rd = 1'b1;
                state_next = ST_ROW_CHK;
            end
            ST_ROW_CHK: begin
                if (stat.bkt_match) begin
                    cmd.row_hit = 1'b1;
                    row_done    = 1'b1;
                end else begin
                    cmd.pow_start = 1'b1;
                    state_next    = ST_POW;
                end
            end
            ST_POW: begin
                if (!stat.pow_done) begin
                    cmd.pow_step = 1'b1;
                end else if (stat.pow_nodecay) begin
                    row_done = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!stat.div_done) begin
                    cmd.div_step = 1'b1;
                end else if (stat.rem_zero) begin
                    state_next = ST_DECAY;
                end else begin
                    row_done = 1'b1;
                end
            end
            ST_DECAY: begin
                cmd.row_decay = 1'b1;
                row_done      = 1'b1;
            end
            ST_STORE: begin
                if (stat.admit && stat.full) begin
                    cmd.rank_op = RK_LAST;
                    state_next  = ST_EV_RD;
                end else if (stat.admit) begin
                    cmd.rank_op = RK_OCC;
                    state_next  = ST_UPD;
                end else if (stat.refresh) begin
                    cmd.rank_op = RK_PRANK;
                    state_next  = ST_UPD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_EV_RD: begin
                cmd.top_rd = 1'b1;
                state_next = ST_EV_DATA;
            end
            ST_EV_DATA: begin
                cmd.ev_cap = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // move on to the next sketch row or to the store update
        if (row_done) begin
            if (stat.row_last) begin
                state_next = ST_STORE;
            end else begin
                cmd.row_inc = 1'b1;
                state_next  = ST_ROW_RD;
            end
        end
    end

endmodule

FILE: hdl/hkts_dpath.sv
// ----------------------------------------------------------------------------
// hkts_dpath
// Datapath: bucket memory, top-k store, column remainder, decay power and
// divisor units, result register.
// ----------------------------------------------------------------------------
module hkts_dpath
    import hkts_pkg::*;
#(
    parameter int ROWS        = ROWS_DEF,
    parameter int COLS        = COLS_DEF,
    parameter int TOPK        = TOPK_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hkts_cmd_t           cmd,
    output hkts_stat_t          stat,
    input  logic [THR_W-1:0]    thr,
    input  logic [BASE_W-1:0]   base,
    input  logic [FP_W-1:0]     in_fp,
    input  logic [RANK_W-1:0]   in_rank,
    input  logic [RND_W-1:0]    in_rnd [RND_ROWS],
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int BKT_DEPTH = ROWS * COLS;
    localparam int ADDR_W    = $clog2(BKT_DEPTH);
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MOD_W     = $clog2(COLS + 2);
    localparam int V_W       = MOD_W + 16;
    localparam int SLOT_W    = (TOPK > 1) ? $clog2(TOPK) : 1;
    localparam int OCC_W     = $clog2(TOPK + 1);
    localparam int BKT_W     = FP_W + COUNT_WIDTH;
    localparam int PROD_W    = P_W + BASE_W;
    localparam int N_W       = PROD_W - 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // operation registers
    logic [FP_W-1:0]   fp_reg, hash_sh_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [RND_W-1:0]  rnd_reg [RND_ROWS];
    logic [2:0]        hash_cnt_reg;
    logic [MOD_W-1:0]  col_rem_reg [ROWS];
    logic [MOD_W-1:0]  col_rem_next [ROWS];
    logic [V_W-1:0]    fold_v [ROWS];
    logic [V_W-1:0]    fold_v_reg [ROWS];
    logic [V_W-1:0]    fold_q [ROWS];
    logic [V_W-1:0]    fold_q_reg [ROWS];

    // top-k store
    logic [OCC_W-1:0]  cur_reg, occ_reg, prank_reg;
    logic [SLOT_W-1:0] order_reg [TOPK];
    logic [FP_W-1:0]   top_fp_mem [TOPK];
    logic [EST_W-1:0]  top_cnt_mem [TOPK];
    logic [FP_W-1:0]   top_fp_q;
    logic [EST_W-1:0]  top_cnt_q;
    logic [EST_W-1:0]  pcount_reg;
    logic              present_reg;
    logic [SLOT_W-1:0] cur_slot;

    // sketch
    logic [BKT_W-1:0]       bkt_mem [BKT_DEPTH];
    logic [BKT_W-1:0]       bkt_q;
    logic [ROW_W-1:0]       row_reg;
    logic [COUNT_WIDTH-1:0] est_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [ADDR_W-1:0]      bkt_addr, bkt_waddr;
    logic [BKT_W-1:0]       bkt_wdata;
    logic                   bkt_we;
    logic [FP_W-1:0]        bkt_fp;
    logic [COUNT_WIDTH-1:0] bkt_cnt, hit_cnt;
    logic                   dec_take;
    logic [MOD_W-1:0]       row_rem;
    logic [31:0]            col;

    // decay power and divisor
    logic [P_W-1:0]         p_reg;
    logic [COUNT_WIDTH-1:0] pow_cnt_reg;
    logic                   pow_done_reg, nodecay_reg;
    logic [PROD_W-1:0]      prod;
    logic [N_W-1:0]         n_val;
    logic [RND_W-1:0]       divisor;
    logic [RND_W-1:0]       div_rem_reg, div_sh_reg, div_rem_next;
    logic [4:0]             div_cnt_reg;
    logic [RND_W:0]         div_sh;

    // result
    logic [EST_W-1:0]    est16;
    logic                upd_reg, ev_valid_reg, rd_valid_reg;
    logic [FP_W-1:0]     ev_fp_reg, rd_fp_reg;
    logic [EST_W-1:0]    rd_cnt_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // column remainder lanes: Horner over 16-bit chunks, MSB first; a chunk
    // takes two steps, a reciprocal estimate of the quotient (low by at most
    // one), then the remainder with one correcting subtract
    for (genvar j = 0; j < ROWS; j++) begin : g_col
        localparam int MOD_J = COLS + 3 - 2 * (j + ROWS);
        localparam logic [V_W-1:0] M_J   = V_W'(MOD_J);
        localparam logic [V_W-1:0] RCP_J = V_W'((64'd1 << V_W) / 64'(MOD_J));
        logic [2*V_W-1:0] q_prod, qm_prod;
        logic [V_W-1:0]   part;

        assign fold_v[j]       = {col_rem_reg[j], hash_sh_reg[FP_W-1 -: 16]};
        assign q_prod          = (2*V_W)'(fold_v[j]) * (2*V_W)'(RCP_J);
        assign fold_q[j]       = q_prod[2*V_W-1:V_W];
        assign qm_prod         = (2*V_W)'(fold_q_reg[j]) * (2*V_W)'(M_J);
        assign part            = fold_v_reg[j] - qm_prod[V_W-1:0];
        assign col_rem_next[j] = (part >= M_J) ? MOD_W'(part - M_J) : MOD_W'(part);
    end

    // bucket address and update values
    assign row_rem  = col_rem_reg[row_reg];
    assign col      = (32'(row_rem) >= COLS) ? 32'(row_rem) - COLS : 32'(row_rem);
    assign bkt_addr = ADDR_W'(32'(row_reg) * COLS + col);
    assign bkt_fp   = bkt_q[BKT_W-1:COUNT_WIDTH];
    assign bkt_cnt  = bkt_q[COUNT_WIDTH-1:0];
    assign dec_take = (bkt_cnt <= COUNT_WIDTH'(1));

    always_comb begin
        logic inc_ok;
        inc_ok  = present_reg || (32'(bkt_cnt) <= 32'(thr));
        hit_cnt = (inc_ok && (bkt_cnt != CNT_MAX)) ? bkt_cnt + COUNT_WIDTH'(1) : bkt_cnt;
    end

    // bucket write port: clearing pass, count-up, decay
    always_comb begin
        bkt_we    = 1'b0;
        bkt_waddr = bkt_addr;
        bkt_wdata = {fp_reg, hit_cnt};
        if (cmd.clr_step) begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_cnt_reg;
            bkt_wdata = '0;
        end else if (cmd.row_hit) begin
            bkt_we = 1'b1;
        end else if (cmd.row_decay) begin
            bkt_we    = 1'b1;
            bkt_wdata = dec_take ? {fp_reg, COUNT_WIDTH'(1)}
                                 : {bkt_fp, bkt_cnt - COUNT_WIDTH'(1)};
        end
    end

    // decay power step and divisor
    assign prod    = PROD_W'(p_reg) * PROD_W'(base);
    assign n_val   = prod[PROD_W-1:16];
    assign divisor = (p_reg[P_W-1:16] == '0) ? RND_W'(1) : p_reg[P_W-1:16];

    // remainder of the random value, one bit a step
    assign div_sh       = {div_rem_reg, div_sh_reg[RND_W-1]};
    assign div_rem_next = (div_sh >= {1'b0, divisor}) ? RND_W'(div_sh - {1'b0, divisor})
                                                      : RND_W'(div_sh);

    // estimate saturated to the output field
    assign est16    = (32'(est_reg) > 32'hFFFF) ? 16'hFFFF : EST_W'(est_reg);
    assign cur_slot = order_reg[cur_reg[SLOT_W-1:0]];

    // status to the controller
    always_comb begin
        stat.hash_last   = (hash_cnt_reg == 3'd7);
        stat.srch_more   = (cur_reg < occ_reg);
        stat.top_match   = (top_fp_q == fp_reg);
        stat.bkt_match   = (bkt_fp == fp_reg);
        stat.row_last    = (32'(row_reg) == ROWS - 1);
        stat.pow_done    = pow_done_reg;
        stat.pow_nodecay = nodecay_reg;
        stat.div_done    = (div_cnt_reg == 5'(RND_W));
        stat.rem_zero    = (div_rem_reg == '0);
        stat.admit       = !present_reg && (17'(est16) == 17'(thr) + 17'd1);
        stat.refresh     = present_reg && (est16 > pcount_reg);
        stat.full        = (occ_reg == OCC_W'(TOPK));
        stat.rd_ok       = (32'(rank_reg) < 32'(occ_reg));
        stat.clr_last    = (32'(clr_cnt_reg) == BKT_DEPTH - 1);
        stat.out_free    = !m_valid_reg || m_tready;
    end

    // bucket memory
    always_ff @(posedge aclk) begin
        if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
        if (cmd.bkt_rd) bkt_q <= bkt_mem[bkt_addr];
    end

    // top-k entry memory
    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            top_fp_mem[cur_slot]  <= fp_reg;
            top_cnt_mem[cur_slot] <= est16;
        end
        if (cmd.top_rd) begin
            top_fp_q  <= top_fp_mem[cur_slot];
            top_cnt_q <= top_cnt_mem[cur_slot];
        end
    end

    // control state: recency order, occupancy, cursors, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            cur_reg     <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TOPK; i++) order_reg[i] <= SLOT_W'(i);
        end else begin
            case (cmd.rank_op)
                RK_ZERO:  cur_reg <= '0;
                RK_INC:   cur_reg <= cur_reg + OCC_W'(1);
                RK_INPUT: cur_reg <= OCC_W'(in_rank);
                RK_LAST:  cur_reg <= OCC_W'(TOPK - 1);
                RK_OCC:   cur_reg <= occ_reg;
                RK_PRANK: cur_reg <= prank_reg;
                default:  cur_reg <= cur_reg;
            endcase

            if (cmd.clr_step) begin
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
            end

            // move the touched entry to newest
            if (cmd.upd) begin
                for (int i = 0; i < TOPK; i++) begin
                    if (i == 0) begin
                        order_reg[0] <= cur_slot;
                    end else if (32'(i) <= 32'(cur_reg)) begin
                        order_reg[i] <= order_reg[i-1];
                    end
                end
                if (stat.admit && !stat.full) occ_reg <= occ_reg + OCC_W'(1);
            end

            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            fp_reg       <= in_fp;
            hash_sh_reg  <= in_fp;
            rank_reg     <= in_rank;
            rnd_reg      <= in_rnd;
            hash_cnt_reg <= '0;
            row_reg      <= '0;
            est_reg      <= '0;
            present_reg  <= 1'b0;
            upd_reg      <= 1'b0;
            ev_valid_reg <= 1'b0;
            ev_fp_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_fp_reg    <= '0;
            rd_cnt_reg   <= '0;
            for (int j = 0; j < ROWS; j++) col_rem_reg[j] <= '0;
        end

        // even step: quotient estimate; odd step: remainder, next chunk
        if (cmd.hash_step) begin
            hash_cnt_reg <= hash_cnt_reg + 3'd1;
            if (!hash_cnt_reg[0]) begin
                fold_v_reg <= fold_v;
                fold_q_reg <= fold_q;
            end else begin
                hash_sh_reg <= {hash_sh_reg[FP_W-17:0], 16'd0};
                col_rem_reg <= col_rem_next;
            end
        end

        if (cmd.srch_cmp && stat.top_match) begin
            present_reg <= 1'b1;
            prank_reg   <= cur_reg;
            pcount_reg  <= top_cnt_q;
        end

        if (cmd.rd_cap) begin
            rd_valid_reg <= 1'b1;
            rd_fp_reg    <= top_fp_q;
            rd_cnt_reg   <= top_cnt_q;
        end

        if (cmd.row_inc) row_reg <= row_reg + ROW_W'(1);

        // estimate is the largest count touched
        if (cmd.row_hit && (hit_cnt > est_reg)) est_reg <= hit_cnt;
        if (cmd.row_decay && dec_take && (est_reg == '0)) est_reg <= COUNT_WIDTH'(1);

        // b^count by repeated truncating Q16 multiplication
        if (cmd.pow_start) begin
            p_reg        <= Q16_ONE;
            pow_cnt_reg  <= '0;
            pow_done_reg <= 1'b0;
            nodecay_reg  <= 1'b0;
        end else if (cmd.pow_step) begin
            if (pow_cnt_reg == bkt_cnt) begin
                pow_done_reg <= 1'b1;
            end else if (n_val[N_W-1:P_W] != '0) begin
                pow_done_reg <= 1'b1;
                nodecay_reg  <= 1'b1;
            end else if (n_val[P_W-1:0] == p_reg) begin
                pow_done_reg <= 1'b1;
            end else begin
                p_reg       <= n_val[P_W-1:0];
                pow_cnt_reg <= pow_cnt_reg + COUNT_WIDTH'(1);
            end
        end

        if (cmd.div_start) begin
            div_rem_reg <= '0;
            div_sh_reg  <= rnd_reg[2'(row_reg)];
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_rem_reg <= div_rem_next;
            div_sh_reg  <= {div_sh_reg[RND_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 5'd1;
        end

        if (cmd.ev_cap) ev_fp_reg <= top_fp_q;

        if (cmd.upd) begin
            upd_reg <= 1'b1;
            if (stat.admit && stat.full) ev_valid_reg <= 1'b1;
        end

        if (cmd.res_load) begin
            m_data_reg <= {4'b0, rd_cnt_reg, rd_fp_reg, rd_valid_reg, ev_fp_reg,
                           ev_valid_reg, upd_reg, present_reg, est16};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: hdl/heavy_keeper_topk_sketch_unit.sv
// ----------------------------------------------------------------------------
// heavy_keeper_topk_sketch_unit
// Top-k frequency sketch with a least-recently-used top-k store.
// ----------------------------------------------------------------------------
// Items enter on the s_ stream (operation in s_tuser, fingerprint, read rank
// and four row random values in s_tdata); one result per item leaves on the
// m_ stream. Thresholds are to be set through the APB port only while idle;
// the block does not enforce this. One item is worked at a time. An insert
// takes the transfer, folds the fingerprint into the row columns in 16-bit
// chunks and searches the store ranks until one matches; then per row it
// reads the bucket and counts up on a hit, or on a miss runs the power loop
// (one Q16 multiply per count step) and then the 31-step remainder unit;
// last it updates the store and loads the result. A read fetches one store
// entry when the rank is occupied; an unused code only loads the result.
// A clear walks the bucket memory, one bucket a cycle.
// After reset the same clearing pass runs before s_tready first rises.
// A finished result sits in the output register; while m_tready is low the
// next item may be taken and worked, and the block then waits to hand over
// its result. Registers reset to threshold 10 and decay base 1.08.
// ----------------------------------------------------------------------------
module heavy_keeper_topk_sketch_unit
    import hkts_pkg::*;
#(
    parameter int ROWS        = ROWS_DEF,
    parameter int COLS        = COLS_DEF,
    parameter int TOPK        = TOPK_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key_fingerprint, read_rank, random_row0..random_row3
    input  logic [S_DATA_W-1:0]   s_tdata,
    // operation
    input  logic [OP_W-1:0]       s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // estimate, was_present, store_updated, evicted_valid,
    // evicted_fingerprint, read_valid, read_fingerprint, read_count
    output logic [M_DATA_W-1:0]   m_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [THR_W-1:0]  thr_reg;
    logic [BASE_W-1:0] base_reg;
    logic [RND_W-1:0]  in_rnd [RND_ROWS];
    hkts_cmd_t         cmd;
    hkts_stat_t        stat;

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_RESET;
            base_reg <= BASE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_THR:  thr_reg  <= pwdata[THR_W-1:0];
                REG_BASE: base_reg <= pwdata[BASE_W-1:0];
                default:  thr_reg  <= thr_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_BASE) ? APB_DATA_W'(base_reg) : APB_DATA_W'(thr_reg);

    // random values per row
    always_comb begin
        for (int j = 0; j < RND_ROWS; j++) begin
            in_rnd[j] = s_tdata[FP_W + RANK_W + j*RND_W +: RND_W];
        end
    end

    hkts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hkts_dpath #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .TOPK        (TOPK),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .thr      (thr_reg),
        .base     (base_reg),
        .in_fp    (s_tdata[FP_W-1:0]),
        .in_rank  (s_tdata[FP_W +: RANK_W]),
        .in_rnd   (in_rnd),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: tb/sv/heavy_keeper_topk_sketch_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heavy_keeper_topk_sketch_unit_tb
// Self-checking bench for the top-k frequency sketch unit. A directed table
// covers the extremes and each special case, then random traffic over a
// small key pool drives admissions, refreshes, evictions and decay. Each
// result is checked field by field against an in-bench sketch predictor.
// ----------------------------------------------------------------------------
module heavy_keeper_topk_sketch_unit_tb;
    import hkts_pkg::*;

    localparam int NROW      = 4;
    localparam int NCOL      = 1024;
    localparam int NTOP      = 16;
    localparam int CNT_MAX   = 65535;
    localparam logic [63:0] DIV_LIM = 64'h7FFF_FFFF;
    // key offset that lands in the same bucket of every row
    localparam logic [63:0] ALL_ROW_STEP = 64'd1019 * 64'd1017 * 64'd1015 * 64'd1013;
    localparam int OP_UNUSED = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_THR  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_BASE = 3'd4;

    typedef struct {
        logic [15:0] est;
        logic        present;
        logic        updated;
        logic        ev_valid;
        logic [63:0] ev_fp;
        logic        rd_valid;
        logic [63:0] rd_fp;
        logic [15:0] rd_cnt;
    } sketch_res_t;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] fp;
        logic [3:0]  rank;
        logic [30:0] rnd;
        int          reps;
        bit          typed;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    heavy_keeper_topk_sketch_unit uut (.*);

    // predictor state
    logic [63:0] bkt_fp [NROW*NCOL];
    int unsigned bkt_cnt [NROW*NCOL];
    logic [63:0] top_fp [NTOP];
    int unsigned top_cnt [NTOP];
    int unsigned top_order [NTOP];
    int unsigned top_occ;
    logic [15:0] thr_q;
    logic [19:0] base_q;

    sketch_res_t pending_q[$];
    int n_err = 0, n_items = 0, n_results = 0, n_admit = 0, n_evict = 0;
    int tx_gap_pct = 37, rx_idle_pct = 57;
    int hold_seq = 0, hold_seen = 0, hold_cnt = 0;
    logic [63:0] key_pool [24];

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        n_err++;
        $display("MISMATCH %0t %s: got %h expected %h", $realtime, what, got, exp);
    endtask

    function automatic logic [63:0] decay_div(input int unsigned cnt);
        logic [95:0] p, n;
        p = 96'd65536;
        for (int unsigned i = 0; i < cnt; i++) begin
            n = (p * {76'd0, base_q}) >> 16;
            if ((n >> 16) > {32'd0, DIV_LIM}) return DIV_LIM + 64'd1;
            if (n == p) break;
            p = n;
        end
        return p[79:16];
    endfunction

    task automatic sketch_reset();
        for (int i = 0; i < NROW*NCOL; i++) begin
            bkt_fp[i] = '0;
            bkt_cnt[i] = 0;
        end
    endtask

    task automatic to_front(input int unsigned r);
        int unsigned slot;
        slot = top_order[r];
        for (int unsigned k = r; k > 0; k--) top_order[k] = top_order[k-1];
        top_order[0] = slot;
    endtask

    // sketch predictor: one item in, one result out
    task automatic sketch_predict(input logic [1:0] op, input logic [63:0] fp,
                                  input logic [3:0] rank, input logic [30:0] rnd [NROW],
                                  output sketch_res_t res);
        bit present;
        int unsigned prank, pslot, est, idx, r, s;
        logic [63:0] col, d;
        res = '{default: '0};
        present = 0; prank = 0; pslot = 0; est = 0;
        if (op == OP_CLEAR) begin
            sketch_reset();
        end else if (op == OP_READ) begin
            if (rank < top_occ) begin
                s = top_order[rank];
                res.rd_valid = 1'b1;
                res.rd_fp = top_fp[s];
                res.rd_cnt = top_cnt[s][15:0];
            end
        end else if (op == OP_INSERT) begin
            for (int unsigned i = 0; i < top_occ; i++) begin
                if (top_fp[top_order[i]] == fp) begin
                    present = 1; prank = i; pslot = top_order[i];
                    break;
                end
            end
            for (int j = 0; j < NROW; j++) begin
                col = fp % (64'd1019 - 64'(2*j));
                idx = j*NCOL + int'(col);
                if (bkt_fp[idx] == fp) begin
                    if (present || bkt_cnt[idx] <= thr_q)
                        if (bkt_cnt[idx] < CNT_MAX) bkt_cnt[idx]++;
                    if (bkt_cnt[idx] > est) est = bkt_cnt[idx];
                end else begin
                    d = decay_div(bkt_cnt[idx]);
                    if (d <= DIV_LIM) begin
                        if (d == 0) d = 1;
                        if ({33'd0, rnd[j]} % d == 0) begin
                            if (bkt_cnt[idx] <= 1) begin
                                bkt_fp[idx] = fp;
                                bkt_cnt[idx] = 1;
                                if (est < 1) est = 1;
                            end else begin
                                bkt_cnt[idx]--;
                            end
                        end
                    end
                end
            end
            if (est > CNT_MAX) est = CNT_MAX;
            res.est = est[15:0];
            res.present = present;
            if (!present) begin
                if (est == thr_q + 1) begin
                    if (top_occ < NTOP) begin
                        r = top_occ;
                        top_occ++;
                    end else begin
                        r = NTOP - 1;
                        res.ev_valid = 1'b1;
                        res.ev_fp = top_fp[top_order[r]];
                        n_evict++;
                    end
                    s = top_order[r];
                    top_fp[s] = fp;
                    top_cnt[s] = est;
                    to_front(r);
                    res.updated = 1'b1;
                    n_admit++;
                end
            end else if (est > top_cnt[pslot]) begin
                top_cnt[pslot] = est;
                to_front(prank);
                res.updated = 1'b1;
            end
        end
    endtask

    // receiver ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_cnt <= 400;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        sketch_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                report("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                e = pending_q.pop_front();
                if (m_tdata[15:0] !== e.est) report("estimate", m_tdata[15:0], e.est);
                if (m_tdata[16] !== e.present) report("was_present", m_tdata[16], e.present);
                if (m_tdata[17] !== e.updated) report("store_updated", m_tdata[17], e.updated);
                if (m_tdata[18] !== e.ev_valid) report("evicted_valid", m_tdata[18], e.ev_valid);
                if (m_tdata[82:19] !== e.ev_fp)
                    report("evicted_fingerprint", m_tdata[82:19], e.ev_fp);
                if (m_tdata[83] !== e.rd_valid) report("read_valid", m_tdata[83], e.rd_valid);
                if (m_tdata[147:84] !== e.rd_fp)
                    report("read_fingerprint", m_tdata[147:84], e.rd_fp);
                if (m_tdata[163:148] !== e.rd_cnt)
                    report("read_count", m_tdata[163:148], e.rd_cnt);
            end
        end
    end

    // one input transfer, then an optional gap
    task automatic send_item(input logic [1:0] op, input logic [63:0] fp, input logic [3:0] rank,
                             input logic [30:0] rnd [NROW], input bit typed);
        sketch_res_t res;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {rnd[3], rnd[2], rnd[1], rnd[0], rank, fp};
        do @(posedge aclk); while (!s_tready);
        sketch_predict(op, fp, rank, rnd, res);
        if (typed) res = '{default: '0};
        pending_q.push_back(res);
        n_items++;
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // APB write then read back
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== val) report("register readback", prdata, val);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        if (addr == ADDR_THR) thr_q = val[15:0];
        else base_q = val[19:0];
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [19:0] base);
        drain();
        reg_write(ADDR_THR, {16'd0, thr});
        reg_write(ADDR_BASE, {12'd0, base});
    endtask

    task automatic random_phase(input int count, input bit pressure);
        logic [30:0] rnd [NROW];
        logic [63:0] fp;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (pressure && n == 10) hold_seq <= hold_seq + 1;
            for (int j = 0; j < NROW; j++) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) rnd[j] = '0;
                else if (pick < 7) rnd[j] = 31'($urandom_range(0, 7));
                else rnd[j] = 31'($urandom);
            end
            fp = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                             : key_pool[$urandom_range(0, 23)];
            pick = $urandom_range(0, 99);
            if (pick < 84) send_item(OP_INSERT, fp, 4'($urandom), rnd, 0);
            else if (pick < 97) send_item(OP_READ, fp, 4'($urandom), rnd, 0);
            else if (pick < 98) send_item(OP_CLEAR, fp, 4'($urandom), rnd, 0);
            else send_item(2'(OP_UNUSED), fp, 4'($urandom), rnd, 0);
        end
    endtask

    // stimulus
    initial begin
        dir_row_t dir [$];
        logic [30:0] rnd [NROW];
        sketch_reset();
        for (int i = 0; i < NTOP; i++) begin
            top_fp[i] = '0; top_cnt[i] = 0; top_order[i] = i;
        end
        top_occ = 0;
        thr_q = THR_RESET;
        base_q = BASE_RESET;
        for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[1] = key_pool[0] + ALL_ROW_STEP;
        key_pool[3] = key_pool[2] + ALL_ROW_STEP;
        key_pool[5] = key_pool[4] - ALL_ROW_STEP;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        dir = '{
            '{OP_READ,      64'd0,                  4'd0,  31'd0,          1, 1},
            '{OP_READ,      64'd0,                  4'd15, 31'h7FFF_FFFF,  1, 1},
            '{2'(OP_UNUSED), 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 31'h7FFF_FFFF, 1, 1},
            '{OP_CLEAR,     64'd0,                  4'd0,  31'd0,          1, 1},
            '{OP_INSERT,    64'd0,                  4'd0,  31'd0,          11, 0},
            '{OP_READ,      64'd0,                  4'd0,  31'd0,          1, 0},
            '{OP_INSERT,    64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 31'h7FFF_FFFF, 2, 0},
            '{OP_INSERT,    64'h8000_0000_0000_0000, 4'd0,  31'd0,          1, 0},
            // colliding key decays the admitted key's buckets
            '{OP_INSERT,    ALL_ROW_STEP,           4'd0,  31'd0,          2, 0},
            '{OP_INSERT,    64'd0,                  4'd0,  31'd0,          2, 0},
            '{OP_INSERT,    64'hDEAD_BEEF_0123_4567, 4'd5,  31'h2AAA_AAAA,  1, 0},
            '{OP_READ,      64'd0,                  4'd1,  31'd0,          1, 0},
            '{OP_CLEAR,     64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 31'h7FFF_FFFF, 1, 1},
            '{OP_INSERT,    64'd0,                  4'd0,  31'd0,          1, 0},
            '{OP_READ,      64'd0,                  4'd0,  31'd0,          1, 0}
        };
        foreach (dir[i]) begin
            for (int k = 0; k < dir[i].reps; k++) begin
                for (int j = 0; j < NROW; j++) rnd[j] = dir[i].rnd;
                send_item(dir[i].op, dir[i].fp, dir[i].rank, rnd, dir[i].typed);
            end
        end

        set_config(16'd0, 20'd65536);
        random_phase(90, 1);
        set_config(16'd2, 20'd1048575);
        random_phase(90, 0);
        tx_gap_pct = 57; rx_idle_pct = 37;
        set_config(16'd65534, 20'd70779);
        random_phase(90, 0);
        set_config(16'd3, 20'd65537);
        random_phase(90, 0);
        tx_gap_pct = 0; rx_idle_pct = 0;
        set_config(16'd1, 20'd80000);
        random_phase(90, 1);

        drain();
        repeat (100) @(posedge aclk);
        $display("Covered %0d items and %0d results over six register settings,", n_items, n_results);
        $display("with %0d store admissions and %0d evictions; %0d mismatches.",
                 n_admit, n_evict, n_err);
        if (n_err == 0 && pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/hkts_pkg.sv
hdl/hkts_ctrl.sv
hdl/hkts_dpath.sv
hdl/heavy_keeper_topk_sketch_unit.sv
tb/sv/heavy_keeper_topk_sketch_unit_tb.sv
